// File: src/lir_pkg.sv
package lir_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int MAX_RATIO    = 16;

  localparam int RATE_W    = 18;
  localparam int PH_W      = 20;
  localparam int SUM_W     = PH_W + 2;
  localparam int DIFF_W    = SAMPLE_WIDTH + 1;
  localparam int PROD_W    = DIFF_W + RATE_W + 1;
  localparam int MAG_W     = SAMPLE_WIDTH + RATE_W;
  localparam int LIM_W     = RATE_W + $clog2(MAX_RATIO + 1);
  localparam int CNT_W     = $clog2(SAMPLE_WIDTH + 1);
  localparam int TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_RATE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE = CFG_IDX_W'(1);

  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic ph_add;
    logic ph_sub;
    logic emit_interp;
    logic emit_copy;
    logic commit;
    logic clear;
  } lir_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last;
    logic ph_lt_or;
    logic brk;
    logic copy_ok;
    logic div_done;
    logic out_free;
  } lir_status_t;

endpackage

// File: src/lir_div.sv
module lir_div import lir_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [MAG_W-1:0]        dvd_i,
  input  logic [RATE_W-1:0]       dvs_i,
  output logic [SAMPLE_WIDTH-1:0] quo_o,
  output logic                    rem_nz_o,
  output logic                    done_o
);

  logic [RATE_W-1:0]       rem_q, rem_d;
  logic [SAMPLE_WIDTH-1:0] low_q, low_d;
  logic [RATE_W-1:0]       dvs_q, dvs_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [RATE_W:0]         trial;
  logic                    ge;

  // dividend is below divisor * 2^SAMPLE_WIDTH, so the top part starts as the remainder
  always_comb begin
    trial  = {rem_q, low_q[SAMPLE_WIDTH-1]};
    ge     = (trial >= {1'b0, dvs_q});
    rem_d  = rem_q;
    low_d  = low_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dvd_i[MAG_W-1:SAMPLE_WIDTH];
      low_d  = dvd_i[SAMPLE_WIDTH-1:0];
      dvs_d  = dvs_i;
      cnt_d  = CNT_W'(SAMPLE_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? RATE_W'(trial - {1'b0, dvs_q}) : trial[RATE_W-1:0];
      low_d = {low_q[SAMPLE_WIDTH-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    dvs_q <= dvs_d;
  end

  assign quo_o    = low_q;
  assign rem_nz_o = |rem_q;
  assign done_o   = done_q;

endmodule

// File: src/lir_datapath.sv
module lir_datapath import lir_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lir_cmd_t                cmd_i,
  output lir_status_t             status_o,
  input  logic [SAMPLE_WIDTH-1:0] s_data_i,
  input  logic                    s_last_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [RATE_W-1:0]       cfg_wdata_i,
  input  logic                    m_ready_i,
  output logic                    m_valid_o,
  output logic [SAMPLE_WIDTH-1:0] m_data_o,
  output logic                    m_last_o
);

  logic [RATE_W-1:0] ir_cfg_q, ir_cfg_d, or_cfg_q, or_cfg_d;
  logic [RATE_W-1:0] ir_eff, or_eff, or_clamp;
  logic [LIM_W-1:0]  ir_lim;

  logic [SAMPLE_WIDTH-1:0] prev_q, prev_d;
  logic                    have_q, have_d;
  logic [PH_W-1:0]         phase_q, phase_d;

  logic [SAMPLE_WIDTH-1:0] cur_q, cur_d;
  logic                    last_q, last_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic [RATE_W-1:0]       ir_q, ir_d, or_q, or_d;
  logic [PH_W-1:0]         ph_q, ph_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  logic                    out_vld_q, out_vld_d;
  logic [SAMPLE_WIDTH-1:0] out_data_q, out_data_d;
  logic                    out_last_q, out_last_d;

  logic [SUM_W-1:0]  nx, nx2, or2;
  logic [PROD_W-1:0] prod_abs;
  logic [SAMPLE_WIDTH-1:0] quo;
  logic              rem_nz, div_done;
  logic [DIFF_W-1:0] prev_x, quo_x, interp_val;
  logic              neg;

  // rate registers, zero read as one, output rate clamped to the ratio limit
  always_comb begin
    ir_cfg_d = ir_cfg_q;
    or_cfg_d = or_cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_INPUT_RATE:  ir_cfg_d = cfg_wdata_i;
        REG_OUTPUT_RATE: or_cfg_d = cfg_wdata_i;
        default: ;
      endcase
    end
    ir_eff   = (ir_cfg_q == '0) ? RATE_W'(1) : ir_cfg_q;
    or_eff   = (or_cfg_q == '0) ? RATE_W'(1) : or_cfg_q;
    ir_lim   = LIM_W'(ir_eff) * LIM_W'(MAX_RATIO);
    or_clamp = (LIM_W'(or_eff) > ir_lim) ? ir_lim[RATE_W-1:0] : or_eff;
  end

  // phase sums for the loop tests and the final-word lookahead
  always_comb begin
    nx  = SUM_W'(ph_q) + SUM_W'(ir_q);
    nx2 = nx + SUM_W'(ir_q);
    or2 = SUM_W'(or_q) << 1;
  end

  assign status_o.have_prev = have_q;
  assign status_o.last      = last_q;
  assign status_o.ph_lt_or  = (SUM_W'(ph_q) < SUM_W'(or_q));
  assign status_o.brk       = last_q && (nx > or2);
  assign status_o.copy_ok   = (nx <= SUM_W'(or_q));
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_vld_q || m_ready_i;

  assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign neg      = prod_q[PROD_W-1];

  lir_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .dvd_i    (prod_abs[MAG_W-1:0]),
    .dvs_i    (or_q),
    .quo_o    (quo),
    .rem_nz_o (rem_nz),
    .done_o   (div_done)
  );

  // floor division: a negative product with a remainder rounds one further down
  always_comb begin
    prev_x     = {prev_q[SAMPLE_WIDTH-1], prev_q};
    quo_x      = {1'b0, quo};
    interp_val = neg ? (prev_x - quo_x - DIFF_W'(rem_nz)) : (prev_x + quo_x);
  end

  always_comb begin
    cur_d   = cur_q;
    last_d  = last_q;
    diff_d  = diff_q;
    ir_d    = ir_q;
    or_d    = or_q;
    ph_d    = ph_q;
    prod_d  = prod_q;
    prev_d  = prev_q;
    have_d  = have_q;
    phase_d = phase_q;
    if (cmd_i.load) begin
      cur_d  = s_data_i;
      last_d = s_last_i;
      diff_d = $signed({s_data_i[SAMPLE_WIDTH-1], s_data_i})
             - $signed({prev_q[SAMPLE_WIDTH-1], prev_q});
      ir_d   = ir_eff;
      or_d   = or_clamp;
      ph_d   = phase_q;
    end
    if (cmd_i.mul) begin
      prod_d = PROD_W'(diff_q) * PROD_W'($signed({1'b0, ph_q[RATE_W-1:0]}));
    end
    if (cmd_i.ph_add) begin
      ph_d = nx[PH_W-1:0];
    end else if (cmd_i.ph_sub) begin
      ph_d = ph_q - PH_W'(or_q);
    end
    if (cmd_i.commit) begin
      prev_d  = cur_q;
      have_d  = 1'b1;
      phase_d = ph_q;
    end else if (cmd_i.clear) begin
      prev_d  = '0;
      have_d  = 1'b0;
      phase_d = '0;
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q && !m_ready_i;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    if (cmd_i.emit_interp) begin
      out_vld_d  = 1'b1;
      out_data_d = interp_val[SAMPLE_WIDTH-1:0];
      out_last_d = last_q && (nx >= SUM_W'(or_q)) && (nx2 > or2);
    end else if (cmd_i.emit_copy) begin
      out_vld_d  = 1'b1;
      out_data_d = cur_q;
      out_last_d = (nx2 > SUM_W'(or_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_cfg_q  <= RATE_RESET;
      or_cfg_q  <= RATE_RESET;
      prev_q    <= '0;
      have_q    <= 1'b0;
      phase_q   <= '0;
      last_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      ir_cfg_q  <= ir_cfg_d;
      or_cfg_q  <= or_cfg_d;
      prev_q    <= prev_d;
      have_q    <= have_d;
      phase_q   <= phase_d;
      last_q    <= last_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    diff_q     <= diff_d;
    ir_q       <= ir_d;
    or_q       <= or_d;
    ph_q       <= ph_d;
    prod_q     <= prod_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_valid_o = out_vld_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

endmodule

// File: src/lir_ctrl.sv
module lir_ctrl import lir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  lir_status_t status_i,
  output lir_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INTERP  = 6'b000010,
    S_DIVGO   = 6'b000100,
    S_DIVWAIT = 6'b001000,
    S_EMIT    = 6'b010000,
    S_COPY    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.have_prev ? S_INTERP : S_COPY;
        end
      end
      S_INTERP: begin
        if (status_i.ph_lt_or) begin
          // positions past the track length only move the phase on
          if (status_i.brk) begin
            cmd_o.ph_add = 1'b1;
          end else begin
            cmd_o.mul = 1'b1;
            state_d   = S_DIVGO;
          end
        end else begin
          cmd_o.ph_sub = 1'b1;
          state_d      = S_COPY;
        end
      end
      S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (status_i.div_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_interp = 1'b1;
          cmd_o.ph_add      = 1'b1;
          state_d           = S_INTERP;
        end
      end
      S_COPY: begin
        if (!status_i.last) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end else if (status_i.copy_ok) begin
          if (status_i.out_free) begin
            cmd_o.emit_copy = 1'b1;
            cmd_o.ph_add    = 1'b1;
          end
        end else begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/linear_interp_resampler_top.sv
// Each interpolated word is a multiply, then a one-bit-per-cycle restoring divide by the
// output rate, then an emit that waits for the output register to be free. End-of-track
// copies emit the current sample and skipped positions only move the phase on. The input
// is taken one word at a time, only while the controller is idle.
// Reset (rst_ni low, asynchronous) sets both rates to 48000, clears the stored
// sample and phase and empties the output register.
module linear_interp_resampler_top import lir_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TDATA_W-1:0]   s_axis_tdata,  // [SAMPLE_WIDTH-1:0] sample_in
  input  logic                 s_axis_tlast,  // track_end
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_W-1:0]   m_axis_tdata,  // [SAMPLE_WIDTH-1:0] sample_out
  output logic                 m_axis_tlast,  // final_out
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [RATE_W-1:0]    cfg_wdata_i
);

  lir_cmd_t                cmd;
  lir_status_t             status;
  logic [SAMPLE_WIDTH-1:0] out_data;

  lir_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lir_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .s_data_i    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .s_last_i    (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (out_data),
    .m_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = TDATA_W'(out_data);

endmodule

// File: sim/linear_interp_resampler_top_tb.sv
module linear_interp_resampler_top_tb import lir_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT           = 2_000_000;
  localparam int SETTLE          = MAX_RATIO * (SAMPLE_WIDTH + 4) + 16;
  localparam int LONG_HOLD       = 2500;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int N_PHASES        = 9;
  // negative entries mean a random rate
  localparam int IR_TAB [N_PHASES] = '{44100, 48000, 1, 8000, 96000, 192000, 192000, -1, -1};
  localparam int OR_TAB [N_PHASES] = '{48000, 44100, 192000, 96000, 8000, 1, 192000, -1, -1};

  localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    final_flag;
  } resampled_t;

  class interp_checker;
    logic [RATE_W-1:0] in_rate  = RATE_RESET;
    logic [RATE_W-1:0] out_rate = RATE_RESET;
    longint            held_sample;
    bit                held_valid;
    longint            phase;
    resampled_t        due[$];
    int                mismatches;

    function void set_rate(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
      if (idx == REG_INPUT_RATE) begin
        in_rate = val;
      end else begin
        out_rate = val;
      end
    endfunction

    function void push_sample(longint val, inout int cnt);
      resampled_t w;
      if (cnt >= 32) return;
      w.sample     = SAMPLE_WIDTH'(val);
      w.final_flag = 1'b0;
      due.insert(due.size(), w);
      cnt++;
    endfunction

    // works out the interpolated words one accepted input word gives
    function void note_input(logic [SAMPLE_WIDTH-1:0] smp, logic track_end);
      longint     cur, ir, orr, ph, diff, num, q;
      int         cnt;
      cur = longint'($signed(smp));
      ir  = (in_rate == 0) ? 1 : longint'(in_rate);
      orr = (out_rate == 0) ? 1 : longint'(out_rate);
      if (orr > MAX_RATIO * ir) orr = MAX_RATIO * ir;
      ph  = phase;
      cnt = 0;
      if (held_valid) begin
        diff = cur - held_sample;
        while (ph < orr) begin
          if (track_end && ph + ir > 2 * orr) break;
          num = diff * ph;
          q   = num / orr;
          if ((num % orr) != 0 && num < 0) q--;
          push_sample(held_sample + q, cnt);
          ph += ir;
        end
        // positions skipped at the track end still move the phase on
        while (ph < orr) ph += ir;
        ph -= orr;
      end
      if (track_end) begin
        while (ph + ir <= orr) begin
          push_sample(cur, cnt);
          ph += ir;
        end
        if (cnt > 0) begin
          due[due.size() - 1].final_flag = 1'b1;
        end
        held_sample = 0;
        held_valid  = 1'b0;
        phase       = 0;
      end else begin
        held_sample = cur;
        held_valid  = 1'b1;
        phase       = ph & ((longint'(1) << PH_W) - 1);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_word(logic [SAMPLE_WIDTH-1:0] got_sample, logic got_final);
      resampled_t w;
      if (due.size() == 0) begin
        report($sformatf("unexpected word sample=%h last=%b", got_sample, got_final));
        return;
      end
      w = due.pop_front();
      if (got_sample !== w.sample)
        report($sformatf("sample %h, want %h", got_sample, w.sample));
      if (got_final !== w.final_flag)
        report($sformatf("last %b, want %b (sample %h)", got_final, w.final_flag, w.sample));
    endtask
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i    = '0;
  logic [RATE_W-1:0]    cfg_wdata_i   = '0;

  interp_checker sb = new();
  int  cycles  = 0;
  bit  hold_off;
  int  tx_run, rx_run;
  bit  tx_calm, rx_calm;

  linear_interp_resampler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("linear_interp_resampler_top verification failed");
      $finish;
    end
  end

  // each stretch is picked at random as busy or calm, calm meaning no idling at all
  function automatic int next_gap(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      calm     = ($urandom_range(0, 2) == 0);
      run_left = $urandom_range(4, 40);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  task send_word(logic [SAMPLE_WIDTH-1:0] smp, logic track_end);
    int gap;
    gap = next_gap(tx_run, tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(smp);
    s_axis_tlast  <= track_end;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(smp, track_end);
  endtask

  task set_rates(int ir, int orate);
    s_axis_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_INPUT_RATE;
    cfg_wdata_i <= RATE_W'(ir);
    @(posedge clk_i);
    sb.set_rate(REG_INPUT_RATE, RATE_W'(ir));
    cfg_addr_i  <= REG_OUTPUT_RATE;
    cfg_wdata_i <= RATE_W'(orate);
    @(posedge clk_i);
    sb.set_rate(REG_OUTPUT_RATE, RATE_W'(orate));
    cfg_we_i    <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = next_gap(rx_run, rx_calm);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_word(m_axis_tdata[SAMPLE_WIDTH-1:0], m_axis_tlast);
    end
  end

  initial begin
    int ir, orate, n, len, k;
    logic [SAMPLE_WIDTH-1:0] smp;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unity ratio, full-scale steps, single-sample track
    send_word(S_MAX, 1'b0);
    send_word(S_MIN, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(S_MAX, 1'b1);
    send_word(S_MIN, 1'b1);
    // ratio above the limit gets clamped to MAX_RATIO
    set_rates(1, 192000);
    send_word(S_MIN, 1'b0);
    send_word(S_MAX, 1'b0);
    send_word(SAMPLE_WIDTH'(100), 1'b1);
    // zero rates behave as one
    set_rates(0, 0);
    send_word(SAMPLE_WIDTH'(5), 1'b0);
    send_word(SAMPLE_WIDTH'(-5), 1'b1);
    // heavy decimation: track ends give no word, nothing flagged last
    set_rates(192000, 1);
    send_word(SAMPLE_WIDTH'(1), 1'b0);
    send_word(SAMPLE_WIDTH'(2), 1'b0);
    send_word(SAMPLE_WIDTH'(3), 1'b1);
    send_word(SAMPLE_WIDTH'(7), 1'b1);
    // rate change with a track open; phase may sit above the new output rate
    set_rates(44100, 48000);
    send_word(SAMPLE_WIDTH'(1000), 1'b0);
    send_word(SAMPLE_WIDTH'(-3000), 1'b0);
    set_rates(44100, 22050);
    send_word(SAMPLE_WIDTH'(250000), 1'b0);
    send_word(SAMPLE_WIDTH'(-250000), 1'b1);

    for (int p = 0; p < N_PHASES; p++) begin
      ir    = (IR_TAB[p] < 0) ? $urandom_range(1, 192000) : IR_TAB[p];
      orate = (OR_TAB[p] < 0) ? $urandom_range(1, 192000) : OR_TAB[p];
      set_rates(ir, orate);
      if (p == 1) hold_off = 1'b1;
      n = 0;
      // tracks may run over the phase end, so rates also change mid-track
      while (n < ITEMS_PER_PHASE) begin
        len = $urandom_range(1, 12);
        for (k = 0; k < len && n < ITEMS_PER_PHASE; k++) begin
          case ($urandom_range(0, 5))
            0:       smp = S_MAX;
            1:       smp = S_MIN;
            2:       smp = SAMPLE_WIDTH'($urandom_range(0, 200) - 100);
            default: smp = SAMPLE_WIDTH'($urandom);
          endcase
          send_word(smp, k == len - 1);
          n++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.due.size() == 0) begin
      $display("linear_interp_resampler_top verification clean");
    end else begin
      $display("linear_interp_resampler_top verification failed");
    end
    $finish;
  end

endmodule
